>>> rtl/core/dfu_pkg.sv
// Shared widths, register codes and pipeline item types of the demons force update.
// Used by dfu_front, dfu_divider and demons_force_update; depends on nothing else.

package dfu_pkg;

	// Three gradient components: x, y, z.
	localparam int LANES = 3;

	// Configuration port: one 32-bit register, word index taken from paddr[2].
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_ALPHA_SQUARED = 1'b0;
	localparam logic [15:0] ALPHA_RESET = 16'd256;

	// Arithmetic widths.
	localparam int GP_W   = 31;  // |g| * |d|
	localparam int DEN_W  = 49;  // n*2^8 + a*d^2
	localparam int X_W    = 57;  // 2*|g|*|d|*2^24 + den, rounding numerator
	localparam int REM_W  = 50;  // 2*den, divisor and remainder
	localparam int QUO_BITS = 33;  // quotient bits kept; larger quotients only saturate
	localparam int OUT_W  = 32;

	// Pipeline depth.
	localparam int FRONT_STAGES = 6;
	localparam int DIV_STAGES   = QUO_BITS;
	localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + 1;

	// Saturation limits in quotient width.
	localparam logic [QUO_BITS-1:0] POS_LIMIT = QUO_BITS'(64'h7FFF_FFFF);
	localparam logic [QUO_BITS-1:0] NEG_LIMIT = QUO_BITS'(64'h8000_0000);
	localparam logic [OUT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [OUT_W-1:0] SAT_NEG = 32'h8000_0000;

	// One component's state while its quotient is worked out bit by bit.
	typedef struct packed {
		logic [REM_W-1:0]    rem;
		logic [QUO_BITS-1:0] xlo;
		logic [QUO_BITS-1:0] quo;
		logic [REM_W-1:0]    dvsr;
		logic                ovf;
		logic                neg;
		logic                zero;
	} div_lane_t;

	typedef struct packed {
		div_lane_t [LANES-1:0] lane;
		logic                  last;
	} item_t;

endpackage

>>> rtl/core/demons_force_update.sv
// Demons force update top level: configuration register, pipeline control and saturation.
// Depends on dfu_pkg, dfu_front and dfu_divider.
// Each result passes through 40 register stages; the 33-stage divider takes one
// quotient bit per stage. One voxel per cycle is taken unless the output stalls.
// Each stage has its own valid bit, so empty stages fill while the output is stalled.
// Reset clears all valid bits and sets alpha_squared to 256 (1.0); no clearing pass.

module demons_force_update (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dfu_pkg::ADDR_W-1:0]    paddr,
	input  logic [dfu_pkg::DATA_W-1:0]    pwdata,
	output logic [dfu_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [15:0]            fixed_value,
	input  logic signed [15:0]            moved_value,
	input  logic signed [15:0]            moving_grad_x,
	input  logic signed [15:0]            moving_grad_y,
	input  logic signed [15:0]            moving_grad_z,
	input  logic signed [15:0]            fixed_grad_x,
	input  logic signed [15:0]            fixed_grad_y,
	input  logic signed [15:0]            fixed_grad_z,
	input  logic                          last_voxel,
	// output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            update_x,
	output logic signed [31:0]            update_y,
	output logic signed [31:0]            update_z,
	output logic                          saturated,
	output logic                          last_out
);
	import dfu_pkg::*;

	logic [15:0]            alpha_q;
	logic [PIPE_STAGES-1:0] vld_q;
	logic [PIPE_STAGES-1:0] vld_next;
	logic [PIPE_STAGES-1:0] en;
	item_t                  front_item;
	item_t                  div_item;
	logic [OUT_W-1:0]       res_val [LANES];
	logic [LANES-1:0]       res_sat;
	logic [OUT_W-1:0]       upd_q [LANES];
	logic                   sat_q;
	logic                   last_q;

	// Configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
		end else if (psel && penable && pwrite && pready
				&& (paddr[ADDR_W-1] == REG_ALPHA_SQUARED)) begin
			alpha_q <= pwdata[15:0];
		end
	end

	always_comb begin
		if (paddr[ADDR_W-1] == REG_ALPHA_SQUARED) begin
			prdata = {16'd0, alpha_q};
		end else begin
			prdata = '0;
		end
	end

	// A stage may load when it is empty or when the stage after it loads.
	always_comb begin
		en[PIPE_STAGES-1] = !vld_q[PIPE_STAGES-1] || out_ready;
		for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign vld_next = {vld_q[PIPE_STAGES-2:0], in_valid};
	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < PIPE_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_next[k];
				end
			end
		end
	end

	dfu_front u_front (
		.clk           (clk),
		.en            (en[FRONT_STAGES-1:0]),
		.alpha_squared (alpha_q),
		.fixed_value   (fixed_value),
		.moved_value   (moved_value),
		.moving_grad_x (moving_grad_x),
		.moving_grad_y (moving_grad_y),
		.moving_grad_z (moving_grad_z),
		.fixed_grad_x  (fixed_grad_x),
		.fixed_grad_y  (fixed_grad_y),
		.fixed_grad_z  (fixed_grad_z),
		.last_voxel    (last_voxel),
		.item_out      (front_item)
	);

	dfu_divider u_divider (
		.clk      (clk),
		.en       (en[FRONT_STAGES +: DIV_STAGES]),
		.item_in  (front_item),
		.item_out (div_item)
	);

	// Sign, saturation and zero forcing of each component.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			res_val[i] = '0;
			res_sat[i] = 1'b0;
			if (!div_item.lane[i].zero) begin
				if (!div_item.lane[i].neg) begin
					if (div_item.lane[i].ovf || (div_item.lane[i].quo > POS_LIMIT)) begin
						res_val[i] = SAT_POS;
						res_sat[i] = 1'b1;
					end else begin
						res_val[i] = div_item.lane[i].quo[OUT_W-1:0];
					end
				end else begin
					if (div_item.lane[i].ovf || (div_item.lane[i].quo > NEG_LIMIT)) begin
						res_val[i] = SAT_NEG;
						res_sat[i] = 1'b1;
					end else begin
						res_val[i] = OUT_W'(0) - div_item.lane[i].quo[OUT_W-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[PIPE_STAGES-1]) begin
			for (int i = 0; i < LANES; i++) begin
				upd_q[i] <= res_val[i];
			end
			sat_q <= |res_sat;
			last_q <= div_item.last;
		end
	end

	assign out_valid = vld_q[PIPE_STAGES-1];
	assign update_x  = upd_q[0];
	assign update_y  = upd_q[1];
	assign update_z  = upd_q[2];
	assign saturated = sat_q;
	assign last_out  = last_q;

endmodule

>>> rtl/core/dfu_front.sv
// Front end of the demons force update: difference, gradient norm, dot product,
// denominator and rounding numerator, in six register stages. Uses dfu_pkg.

module dfu_front (
	input  logic                                clk,
	input  logic [dfu_pkg::FRONT_STAGES-1:0]    en,
	input  logic [15:0]                         alpha_squared,
	input  logic signed [15:0]                  fixed_value,
	input  logic signed [15:0]                  moved_value,
	input  logic signed [15:0]                  moving_grad_x,
	input  logic signed [15:0]                  moving_grad_y,
	input  logic signed [15:0]                  moving_grad_z,
	input  logic signed [15:0]                  fixed_grad_x,
	input  logic signed [15:0]                  fixed_grad_y,
	input  logic signed [15:0]                  fixed_grad_z,
	input  logic                                last_voxel,
	output dfu_pkg::item_t                      item_out
);
	import dfu_pkg::*;

	logic signed [15:0] mg [LANES];
	logic signed [15:0] fg [LANES];
	logic signed [31:0] sq_full [LANES];
	logic signed [31:0] dp_full [LANES];

	// Stage 1
	logic signed [16:0] d_s1;
	logic signed [15:0] mg_s1 [LANES];
	logic [30:0]        sq_s1 [LANES];
	logic signed [31:0] dp_s1 [LANES];
	logic               last_s1;

	// Stage 2
	logic [15:0]        dm_abs;
	logic [15:0]        gm_abs [LANES];
	logic [31:0]        gp_full [LANES];
	logic [31:0]        dm2_full;
	logic [31:0]        dm2_s2;
	logic [31:0]        n_s2;
	logic signed [32:0] dot_s2;
	logic [GP_W-1:0]    gp_s2 [LANES];
	logic               gneg_s2 [LANES];
	logic               gzero_s2 [LANES];
	logic               dneg_s2;
	logic               dzero_s2;
	logic               last_s2;

	// Stage 3
	logic [47:0]        aterm;
	logic               zero_all;
	logic               sneg;
	logic [47:0]        aterm_s3;
	logic [31:0]        n_s3;
	logic [GP_W-1:0]    gp_s3 [LANES];
	logic               neg_s3 [LANES];
	logic               zero_s3 [LANES];
	logic               last_s3;

	// Stage 4
	logic [DEN_W-1:0]   den_s4;
	logic [GP_W-1:0]    gp_s4 [LANES];
	logic               neg_s4 [LANES];
	logic               zero_s4 [LANES];
	logic               last_s4;

	// Stage 5
	logic [X_W-1:0]     x_s5 [LANES];
	logic [REM_W-1:0]   y_s5;
	logic               neg_s5 [LANES];
	logic               zero_s5 [LANES];
	logic               last_s5;

	// Stage 6
	item_t              item_s6;

	assign mg[0] = moving_grad_x;
	assign mg[1] = moving_grad_y;
	assign mg[2] = moving_grad_z;
	assign fg[0] = fixed_grad_x;
	assign fg[1] = fixed_grad_y;
	assign fg[2] = fixed_grad_z;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			sq_full[i] = mg[i] * mg[i];
			dp_full[i] = mg[i] * fg[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			d_s1 <= {fixed_value[15], fixed_value} - {moved_value[15], moved_value};
			for (int i = 0; i < LANES; i++) begin
				mg_s1[i] <= mg[i];
				sq_s1[i] <= sq_full[i][30:0];
				dp_s1[i] <= dp_full[i];
			end
			last_s1 <= last_voxel;
		end
	end

	always_comb begin
		dm_abs = d_s1[16] ? 16'(-d_s1) : d_s1[15:0];
		dm2_full = dm_abs * dm_abs;
		for (int i = 0; i < LANES; i++) begin
			gm_abs[i] = mg_s1[i][15] ? 16'(-mg_s1[i]) : mg_s1[i][15:0];
			gp_full[i] = gm_abs[i] * dm_abs;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			dm2_s2 <= dm2_full;
			n_s2 <= {1'b0, sq_s1[0]} + {1'b0, sq_s1[1]} + {1'b0, sq_s1[2]};
			dot_s2 <= 33'(dp_s1[0]) + 33'(dp_s1[1]) + 33'(dp_s1[2]);
			for (int i = 0; i < LANES; i++) begin
				gp_s2[i] <= gp_full[i][GP_W-1:0];
				gneg_s2[i] <= mg_s1[i][15];
				gzero_s2[i] <= (mg_s1[i] == '0);
			end
			dneg_s2 <= d_s1[16];
			dzero_s2 <= (d_s1 == '0);
			last_s2 <= last_s1;
		end
	end

	// The scale is negative only for a negative difference with a positive dot product;
	// a negative difference with a zero dot product gives no update at all.
	always_comb begin
		aterm = alpha_squared * dm2_s2;
		zero_all = dzero_s2 || (n_s2 == '0) || (dneg_s2 && (dot_s2 == '0));
		sneg = dneg_s2 && !dot_s2[32] && (dot_s2 != '0);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			aterm_s3 <= aterm;
			n_s3 <= n_s2;
			for (int i = 0; i < LANES; i++) begin
				gp_s3[i] <= gp_s2[i];
				neg_s3[i] <= sneg ^ gneg_s2[i];
				zero_s3[i] <= zero_all || gzero_s2[i];
			end
			last_s3 <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			den_s4 <= DEN_W'({n_s3, 8'd0}) + DEN_W'(aterm_s3);
			for (int i = 0; i < LANES; i++) begin
				gp_s4[i] <= gp_s3[i];
				neg_s4[i] <= neg_s3[i];
				zero_s4[i] <= zero_s3[i];
			end
			last_s4 <= last_s3;
		end
	end

	// Rounded quotient is floor((2*num + den) / (2*den)) with num = |g|*|d|*2^24.
	always_ff @(posedge clk) begin
		if (en[4]) begin
			y_s5 <= {den_s4, 1'b0};
			for (int i = 0; i < LANES; i++) begin
				x_s5[i] <= X_W'({gp_s4[i], 25'd0}) + X_W'(den_s4);
				neg_s5[i] <= neg_s4[i];
				zero_s5[i] <= zero_s4[i];
			end
			last_s5 <= last_s4;
		end
	end

	// A quotient of 2^33 or more can only saturate, so it is flagged here and the
	// divider works out the low 33 quotient bits only.
	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int i = 0; i < LANES; i++) begin
				item_s6.lane[i].rem  <= REM_W'(x_s5[i][X_W-1:QUO_BITS]);
				item_s6.lane[i].xlo  <= x_s5[i][QUO_BITS-1:0];
				item_s6.lane[i].quo  <= '0;
				item_s6.lane[i].dvsr <= y_s5;
				item_s6.lane[i].ovf  <= (REM_W'(x_s5[i][X_W-1:QUO_BITS]) >= y_s5);
				item_s6.lane[i].neg  <= neg_s5[i];
				item_s6.lane[i].zero <= zero_s5[i];
			end
			item_s6.last <= last_s5;
		end
	end

	assign item_out = item_s6;

endmodule

>>> rtl/core/dfu_divider.sv
// Pipelined restoring divider: one quotient bit per stage for all three components.
// Uses dfu_pkg for the item type and widths.

module dfu_divider (
	input  logic                              clk,
	input  logic [dfu_pkg::DIV_STAGES-1:0]    en,
	input  dfu_pkg::item_t                    item_in,
	output dfu_pkg::item_t                    item_out
);
	import dfu_pkg::*;

	item_t div_s [DIV_STAGES];

	function automatic div_lane_t div_step(div_lane_t a);
		logic [REM_W:0] r2;
		div_lane_t      b;
		r2 = {a.rem, a.xlo[QUO_BITS-1]};
		b = a;
		b.xlo = {a.xlo[QUO_BITS-2:0], 1'b0};
		if (r2 >= {1'b0, a.dvsr}) begin
			b.rem = REM_W'(r2 - {1'b0, a.dvsr});
			b.quo = {a.quo[QUO_BITS-2:0], 1'b1};
		end else begin
			b.rem = r2[REM_W-1:0];
			b.quo = {a.quo[QUO_BITS-2:0], 1'b0};
		end
		return b;
	endfunction

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		item_t prev;
		item_t nxt;

		if (j == 0) begin : g_first
			assign prev = item_in;
		end else begin : g_rest
			assign prev = div_s[j-1];
		end

		always_comb begin
			nxt.last = prev.last;
			for (int i = 0; i < LANES; i++) begin
				nxt.lane[i] = div_step(prev.lane[i]);
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				div_s[j] <= nxt;
			end
		end
	end

	assign item_out = div_s[DIV_STAGES-1];

endmodule

>>> verif/tb_demons_force_update.sv
`timescale 1ns / 1ps
// Testbench for demons_force_update: drives voxel transactions and APB writes and reads, predicts
// each update vector in exact fixed point and checks every output transaction.
// Depends on dfu_pkg and the demons_force_update RTL.

module tb_demons_force_update;

	localparam int CLK_HALF = 6;
	localparam int LATENCY = 40;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam logic [dfu_pkg::ADDR_W-1:0] ALPHA_ADDR =
		dfu_pkg::ADDR_W'(4 * int'(dfu_pkg::REG_ALPHA_SQUARED));
	localparam longint unsigned Q_POS_MAX = 64'h7FFF_FFFF;
	localparam longint unsigned Q_NEG_MAX = 64'h8000_0000;

	typedef struct {
		logic signed [15:0] fixed_value;
		logic signed [15:0] moved_value;
		logic signed [15:0] mgrad[3];
		logic signed [15:0] fgrad[3];
		logic               last_voxel;
	} voxel_t;

	typedef struct {
		logic signed [31:0] upd[3];
		logic               saturated;
		logic               last_out;
	} update_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [dfu_pkg::ADDR_W-1:0] paddr;
	logic [dfu_pkg::DATA_W-1:0] pwdata, prdata;
	logic in_valid, in_ready;
	logic signed [15:0] fixed_value, moved_value;
	logic signed [15:0] moving_grad_x, moving_grad_y, moving_grad_z;
	logic signed [15:0] fixed_grad_x, fixed_grad_y, fixed_grad_z;
	logic last_voxel;
	logic out_valid, out_ready;
	logic signed [31:0] update_x, update_y, update_z;
	logic saturated, last_out;

	logic [15:0] alpha_model;
	update_t     expected_updates[$];
	int          error_count;
	int          hold_cycles;
	int          rx_stall_left;
	bit          tx_idle_en;
	bit          rx_idle_en;
	longint      cycle_count;
	string       lane_name[3] = '{"update_x", "update_y", "update_z"};

	demons_force_update dut (.*);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Bit 32 of the result flags a clipped magnitude.
	function automatic logic [32:0] scale_component(input longint g, input int sgn,
			input longint unsigned dm, input longint unsigned den);
		longint unsigned gm, num, q;
		int s;
		if (g == 0 || sgn == 0)
			return '0;
		s = (g < 0) ? -sgn : sgn;
		gm = (g < 0) ? -g : g;
		num = (gm * dm) << 24;
		q = (2 * num + den) / (2 * den);
		if (s > 0) begin
			if (q > Q_POS_MAX)
				return {1'b1, 32'h7FFF_FFFF};
			return {1'b0, 32'(q)};
		end
		if (q > Q_NEG_MAX)
			return {1'b1, 32'h8000_0000};
		return {1'b0, 32'(-q)};
	endfunction

	function automatic update_t predict_update(input voxel_t v, input logic [15:0] alpha);
		update_t r;
		longint d, dot;
		longint unsigned n, dm, den;
		longint g[3];
		int sgn;
		logic [32:0] c;
		r.saturated = 1'b0;
		r.last_out = v.last_voxel;
		d = longint'(v.fixed_value) - longint'(v.moved_value);
		n = 0;
		dot = 0;
		for (int i = 0; i < 3; i++) begin
			g[i] = longint'(v.mgrad[i]);
			n += g[i] * g[i];
			dot += g[i] * longint'(v.fgrad[i]);
			r.upd[i] = '0;
		end
		if (d != 0 && n != 0) begin
			dm = (d < 0) ? -d : d;
			den = (n << 8) + 64'(alpha) * dm * dm;
			// A negative scale only survives when the two gradients point the same way.
			if (d > 0)
				sgn = 1;
			else if (dot > 0)
				sgn = -1;
			else if (dot < 0)
				sgn = 1;
			else
				sgn = 0;
			for (int i = 0; i < 3; i++) begin
				c = scale_component(g[i], sgn, dm, den);
				r.upd[i] = c[31:0];
				r.saturated |= c[32];
			end
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [15:0] small_value(input int span);
		return 16'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic voxel_t make_voxel(input int f, input int m, input int mx, input int my,
			input int mz, input int fx, input int fy, input int fz, input bit last);
		voxel_t v;
		v.fixed_value = 16'(f);
		v.moved_value = 16'(m);
		v.mgrad = '{16'(mx), 16'(my), 16'(mz)};
		v.fgrad = '{16'(fx), 16'(fy), 16'(fz)};
		v.last_voxel = last;
		return v;
	endfunction

	function automatic voxel_t random_voxel();
		voxel_t v;
		int kind, span, pick;
		logic signed [15:0] tmp;
		kind = $urandom_range(0, 9);
		span = ($urandom_range(0, 1) == 1) ? 300 : 8;
		v.fixed_value = 16'($urandom);
		v.moved_value = 16'($urandom);
		for (int i = 0; i < 3; i++) begin
			v.mgrad[i] = 16'($urandom);
			v.fgrad[i] = 16'($urandom);
		end
		v.last_voxel = ($urandom_range(0, 15) == 0);
		case (kind)
			5, 6: begin
				v.fixed_value = small_value(span);
				v.moved_value = small_value(span);
				for (int i = 0; i < 3; i++) begin
					v.mgrad[i] = small_value(span);
					v.fgrad[i] = small_value(span);
				end
			end
			7: v.moved_value = v.fixed_value;
			8: begin
				v.mgrad = '{16'sd0, 16'sd0, 16'sd0};
				if ($urandom_range(0, 1) == 1)
					v.mgrad[$urandom_range(0, 2)] = small_value(span);
			end
			9: begin
				// Non-positive difference with the fixed gradient zero, aligned or opposed.
				if (v.fixed_value > v.moved_value) begin
					tmp = v.fixed_value;
					v.fixed_value = v.moved_value;
					v.moved_value = tmp;
				end
				pick = $urandom_range(0, 2);
				for (int i = 0; i < 3; i++)
					v.fgrad[i] = (pick == 0) ? 16'sd0 : (pick == 1) ? v.mgrad[i] : -v.mgrad[i];
			end
			default: ;
		endcase
		return v;
	endfunction

	task automatic send_voxel(input voxel_t v);
		in_valid <= 1'b1;
		fixed_value <= v.fixed_value;
		moved_value <= v.moved_value;
		moving_grad_x <= v.mgrad[0];
		moving_grad_y <= v.mgrad[1];
		moving_grad_z <= v.mgrad[2];
		fixed_grad_x <= v.fgrad[0];
		fixed_grad_y <= v.fgrad[1];
		fixed_grad_z <= v.fgrad[2];
		last_voxel <= v.last_voxel;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_updates.push_back(predict_update(v, alpha_model));
	endtask

	task automatic pause_input(input int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_random_voxels(input int count);
		repeat (count) begin
			send_voxel(random_voxel());
			if (tx_idle_en)
				pause_input(pick_gap());
		end
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_updates.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_alpha(input logic [15:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ALPHA_ADDR;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		alpha_model = value;
	endtask

	task automatic read_alpha();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ALPHA_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(alpha_model)) begin
			$error("alpha_squared: expected %0d, actual %0d", alpha_model, prdata);
			error_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_update();
		update_t want;
		logic signed [31:0] got[3];
		got = '{update_x, update_y, update_z};
		if (expected_updates.size() == 0) begin
			$error("update transaction with none expected: x=%0d y=%0d z=%0d",
				update_x, update_y, update_z);
			error_count++;
			return;
		end
		want = expected_updates.pop_front();
		for (int i = 0; i < 3; i++)
			if (got[i] !== want.upd[i]) begin
				$error("%s: expected %0d, actual %0d", lane_name[i], want.upd[i], got[i]);
				error_count++;
			end
		if (saturated !== want.saturated) begin
			$error("saturated: expected %0b, actual %0b", want.saturated, saturated);
			error_count++;
		end
		if (last_out !== want.last_out) begin
			$error("last_out: expected %0b, actual %0b", want.last_out, last_out);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_update();
	end

	// Output side: a requested long hold first, then random stalls when enabled.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles--;
		end else if (rx_stall_left > 0) begin
			out_ready <= 1'b0;
			rx_stall_left--;
		end else if (rx_idle_en && $urandom_range(0, 99) < 20) begin
			out_ready <= 1'b0;
			rx_stall_left = pick_gap();
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** demons_force_update: FAILED **");
			$finish;
		end
	end

	task automatic test_register_reset();
		read_alpha();
	endtask

	task automatic test_directed_cases();
		voxel_t cases[$];
		cases.push_back(make_voxel(0, 0, 0, 0, 0, 0, 0, 0, 0));
		cases.push_back(make_voxel(100, 100, 300, -20, 7, 5, 5, 5, 0));
		cases.push_back(make_voxel(500, 0, 0, 0, 0, 256, 256, 256, 1));
		cases.push_back(make_voxel(0, 256, 256, 0, 0, 256, 0, 0, 0));
		cases.push_back(make_voxel(0, 256, 256, 0, 0, -256, 0, 0, 0));
		cases.push_back(make_voxel(0, 256, 256, 0, 0, 0, 256, 0, 1));
		cases.push_back(make_voxel(512, 0, 100, -200, 300, -7, 9, 1, 0));
		cases.push_back(make_voxel(32767, -32768, -32768, -32768, -32768,
			32767, 32767, 32767, 1));
		cases.push_back(make_voxel(-32768, 32767, 32767, -32768, 1,
			-32768, -32768, -32768, 0));
		cases.push_back(make_voxel(-32768, 32767, 32767, 32767, 32767,
			32767, 32767, 32767, 1));
		cases.push_back(make_voxel(1, 0, -1, 1, -1, 0, 0, 0, 0));
		cases.push_back(make_voxel(-1, 0, 1, 1, 1, 1, -1, 1, 1));
		foreach (cases[i]) begin
			send_voxel(cases[i]);
			pause_input(i % 3);
		end
		wait_drain();
	endtask

	task automatic test_alpha_extremes();
		write_alpha(16'd0);
		read_alpha();
		// Without the diff-squared term small gradients clip; a quotient of exactly 2^31
		// fits only on the negative side.
		send_voxel(make_voxel(32767, -32768, 1, 0, 0, 0, 0, 0, 0));
		send_voxel(make_voxel(32767, -32768, -1, 0, 0, 0, 0, 0, 1));
		send_voxel(make_voxel(32767, -1, -1, 0, 0, 0, 0, 0, 0));
		send_voxel(make_voxel(32767, -1, 1, 0, 0, 0, 0, 0, 0));
		send_voxel(make_voxel(100, 0, 1, -1, 200, 3, 3, 3, 1));
		send_random_voxels(150);
		wait_drain();
		write_alpha(16'hFFFF);
		read_alpha();
		send_random_voxels(150);
		wait_drain();
		write_alpha(16'd1);
		send_random_voxels(150);
		wait_drain();
	endtask

	task automatic test_output_backpressure();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		hold_cycles = 300;
		repeat (120) send_voxel(random_voxel());
		wait_drain();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	task automatic test_random_phases();
		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 0)
				write_alpha(dfu_pkg::ALPHA_RESET);
			else if (phase % 2 == 1)
				write_alpha(16'($urandom_range(0, 1023)));
			else
				write_alpha(16'($urandom));
			read_alpha();
			tx_idle_en = (phase % 4 != 2);
			rx_idle_en = (phase % 4 != 3);
			send_random_voxels(90);
			wait_drain();
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		fixed_value <= '0;
		moved_value <= '0;
		moving_grad_x <= '0;
		moving_grad_y <= '0;
		moving_grad_z <= '0;
		fixed_grad_x <= '0;
		fixed_grad_y <= '0;
		fixed_grad_z <= '0;
		last_voxel <= 1'b0;
		out_ready <= 1'b0;
		alpha_model = dfu_pkg::ALPHA_RESET;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_reset();
		test_directed_cases();
		test_alpha_extremes();
		test_output_backpressure();
		test_random_phases();
		wait_drain();
		repeat (2 * LATENCY) @(posedge clk);
		if (error_count == 0 && expected_updates.size() == 0)
			$display("** demons_force_update: PASSED **");
		else
			$display("** demons_force_update: FAILED **");
		$finish;
	end

endmodule

>>> demons_force_update.f
rtl/core/dfu_pkg.sv
rtl/core/dfu_front.sv
rtl/core/dfu_divider.sv
rtl/core/demons_force_update.sv
verif/tb_demons_force_update.sv
